>>> hw/rtl/rgb_component_to_gray_top_macros.svh
// Assertion macros for the gray conversion block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef RGB_COMPONENT_TO_GRAY_TOP_MACROS_SVH
`define RGB_COMPONENT_TO_GRAY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RGTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RGTG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RGTG_ASSERT_IMP(lbl, ante, cons)
`define RGTG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/rgtg_pkg.sv
`timescale 1ns / 1ps
package rgtg_pkg;

  typedef enum logic [1:0] {OP_RAW, OP_PROD, OP_POW, OP_ZERO} op_e;

  localparam logic [3:0] MODE_R        = 4'd0;
  localparam logic [3:0] MODE_G        = 4'd1;
  localparam logic [3:0] MODE_B        = 4'd2;
  localparam logic [3:0] MODE_RG_PROD  = 4'd3;
  localparam logic [3:0] MODE_RB_PROD  = 4'd4;
  localparam logic [3:0] MODE_GB_PROD  = 4'd5;
  localparam logic [3:0] MODE_R_POW    = 4'd6;
  localparam logic [3:0] MODE_G_POW    = 4'd7;
  localparam logic [3:0] MODE_B_POW    = 4'd8;
  localparam logic [3:0] MODE_RG_RATIO = 4'd9;
  localparam logic [3:0] MODE_GB_RATIO = 4'd10;
  localparam logic [3:0] MODE_BR_RATIO = 4'd11;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_EXP  = 1'b1;

  localparam logic [15:0] EXP_RESET = 16'd8192;
  localparam logic [15:0] RATIO_EXP = 16'd3686;

  // one classified request
  typedef struct packed {
    op_e         op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        ratio;
    logic [15:0] e;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  typedef logic [19:0] log_tab_t [256];
  typedef logic [29:0] c_tab_t [17];

  // log2 in Q16 by repeated squaring of the mantissa
  function automatic logic [19:0] log2_q16(input logic [31:0] n);
    logic [31:0] p;
    logic [63:0] m;
    logic [31:0] res;
    p = 32'd0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (p + 32'd1)) != 32'd0) p = p + 32'd1;
    end
    m = (p <= 32'd16) ? ({32'd0, n} << (32'd16 - p)) : ({32'd0, n} >> (p - 32'd16));
    res = p << 16;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 16;
      if (m >= 64'd131072) begin
        m = m >> 1;
        res[b] = 1'b1;
      end
    end
    return res[19:0];
  endfunction

  function automatic log_tab_t build_log_tab(input int unsigned base);
    log_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = log2_q16(32'(base + 32'(i)));
    end
    return tab;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = v_in;
    res = 64'd0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // c[i] = 2^(30 - 2^-i), i.e. 2^(-2^-i) in Q30 : successive square roots
  function automatic c_tab_t build_c_tab();
    c_tab_t tab;
    logic [63:0] c;
    c = 64'd1 << 29;
    tab[0] = c[29:0];
    for (int i = 1; i < 17; i++) begin
      c = isqrt64(c << 30);
      tab[i] = c[29:0];
    end
    return tab;
  endfunction

endpackage

>>> hw/rtl/rgtg_front.sv
`timescale 1ns / 1ps
module rgtg_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [3:0]          mode_i,
  input  logic [15:0]         exponent_i,
  input  rgtg_pkg::qstat_t    q_stat_i,
  output logic                push_o,
  output rgtg_pkg::cmd_t      cmd_o
);

  // take a request whenever the queue has room
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // decode the mode into operation and operands
  always_comb begin
    cmd_o.op    = rgtg_pkg::OP_ZERO;
    cmd_o.x     = 8'd0;
    cmd_o.y     = 8'd0;
    cmd_o.ratio = 1'b0;
    cmd_o.e     = exponent_i;
    case (mode_i)
      rgtg_pkg::MODE_R: begin
        cmd_o.op = rgtg_pkg::OP_RAW;
        cmd_o.x  = red_i;
      end
      rgtg_pkg::MODE_G: begin
        cmd_o.op = rgtg_pkg::OP_RAW;
        cmd_o.x  = green_i;
      end
      rgtg_pkg::MODE_B: begin
        cmd_o.op = rgtg_pkg::OP_RAW;
        cmd_o.x  = blue_i;
      end
      rgtg_pkg::MODE_RG_PROD: begin
        cmd_o.op = rgtg_pkg::OP_PROD;
        cmd_o.x  = red_i;
        cmd_o.y  = green_i;
      end
      rgtg_pkg::MODE_RB_PROD: begin
        cmd_o.op = rgtg_pkg::OP_PROD;
        cmd_o.x  = red_i;
        cmd_o.y  = blue_i;
      end
      rgtg_pkg::MODE_GB_PROD: begin
        cmd_o.op = rgtg_pkg::OP_PROD;
        cmd_o.x  = green_i;
        cmd_o.y  = blue_i;
      end
      rgtg_pkg::MODE_R_POW: begin
        cmd_o.op = rgtg_pkg::OP_POW;
        cmd_o.x  = red_i;
      end
      rgtg_pkg::MODE_G_POW: begin
        cmd_o.op = rgtg_pkg::OP_POW;
        cmd_o.x  = green_i;
      end
      rgtg_pkg::MODE_B_POW: begin
        cmd_o.op = rgtg_pkg::OP_POW;
        cmd_o.x  = blue_i;
      end
      rgtg_pkg::MODE_RG_RATIO: begin
        cmd_o.op    = rgtg_pkg::OP_POW;
        cmd_o.x     = red_i;
        cmd_o.y     = green_i;
        cmd_o.ratio = 1'b1;
        cmd_o.e     = rgtg_pkg::RATIO_EXP;
      end
      rgtg_pkg::MODE_GB_RATIO: begin
        cmd_o.op    = rgtg_pkg::OP_POW;
        cmd_o.x     = green_i;
        cmd_o.y     = blue_i;
        cmd_o.ratio = 1'b1;
        cmd_o.e     = rgtg_pkg::RATIO_EXP;
      end
      rgtg_pkg::MODE_BR_RATIO: begin
        cmd_o.op    = rgtg_pkg::OP_POW;
        cmd_o.x     = blue_i;
        cmd_o.y     = red_i;
        cmd_o.ratio = 1'b1;
        cmd_o.e     = rgtg_pkg::RATIO_EXP;
      end
      default: begin
        cmd_o.op = rgtg_pkg::OP_ZERO;
      end
    endcase
  end

endmodule

>>> hw/rtl/rgtg_queue.sv
`timescale 1ns / 1ps
module rgtg_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rgtg_pkg::cmd_t   cmd_i,
  input  logic             pop_i,
  output rgtg_pkg::cmd_t   cmd_o,
  output rgtg_pkg::qstat_t stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rgtg_pkg::cmd_t mem_q [DEPTH];
  logic [AW-1:0]  wptr_q, wptr_d;
  logic [AW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign cmd_o        = mem_q[rptr_q];

  // advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

>>> hw/rtl/rgtg_back.sv
`timescale 1ns / 1ps
module rgtg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rgtg_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     gray_o
);

  // stage 0 logs, stage 1 scaling, stages 2..17 exp2 steps, stage 18 output
  localparam int unsigned NST = 19;

  localparam rgtg_pkg::log_tab_t LX_TAB = rgtg_pkg::build_log_tab(0);
  localparam rgtg_pkg::log_tab_t LD_TAB = rgtg_pkg::build_log_tab(255);
  localparam rgtg_pkg::c_tab_t   C_TAB  = rgtg_pkg::build_c_tab();

  typedef struct packed {
    rgtg_pkg::op_e op;
    logic [7:0]    early;
    logic [15:0]   prod;
    logic          zb;
    logic          ez;
    logic [19:0]   a;
    logic [15:0]   e;
    logic [7:0]    k;
    logic [15:0]   f;
    logic [30:0]   acc;
    logic [7:0]    gray;
  } pl_t;

  pl_t            pipe_q [NST];
  pl_t            pipe_d [NST];
  logic [NST-1:0] vld_q;
  logic           adv;

  assign adv         = !vld_q[NST-1] || out_ready_i;
  assign pop_o       = cmd_valid_i && adv;
  assign out_valid_o = vld_q[NST-1];
  assign gray_o      = pipe_q[NST-1].gray;

  always_comb begin
    logic [19:0] lx;
    logic [19:0] ld;
    logic [35:0] t;
    logic [16:0] ps;
    logic [60:0] mp;
    logic [38:0] v39;
    logic [38:0] vs;
    logic [5:0]  sh;
    logic [7:0]  sat;

    // look up both logs and take the difference
    pipe_d[0]       = '0;
    pipe_d[0].op    = cmd_i.op;
    pipe_d[0].early = cmd_i.x;
    pipe_d[0].prod  = 16'(cmd_i.x) * 16'(cmd_i.y);
    pipe_d[0].zb    = (cmd_i.x == 8'd0);
    pipe_d[0].ez    = (cmd_i.e == 16'd0);
    pipe_d[0].e     = cmd_i.e;
    lx = LX_TAB[cmd_i.x];
    ld = LD_TAB[cmd_i.ratio ? cmd_i.y : 8'd0];
    pipe_d[0].a = (ld > lx) ? (ld - lx) : 20'd0;

    // scale by the exponent, split into shift and fraction; for products, scale down by 255
    pipe_d[1] = pipe_q[0];
    t = 36'(pipe_q[0].a) * 36'(pipe_q[0].e);
    pipe_d[1].k   = t[35:28];
    pipe_d[1].f   = t[27:12];
    pipe_d[1].acc = 31'h4000_0000;
    ps = 17'(pipe_q[0].prod) + 17'(pipe_q[0].prod[15:8]) + 17'd1;
    if (pipe_q[0].op == rgtg_pkg::OP_PROD) begin
      pipe_d[1].early = ps[15:8];
    end

    // one exp2 fraction bit per stage
    for (int i = 1; i < 17; i++) begin
      pipe_d[i+1] = pipe_q[i];
      mp = 61'(pipe_q[i].acc) * 61'(C_TAB[i]);
      if (pipe_q[i].f[16-i]) begin
        pipe_d[i+1].acc = mp[60:30];
      end
    end

    // apply the integer shift, saturate and pick the result
    pipe_d[NST-1] = pipe_q[NST-2];
    v39 = {pipe_q[NST-2].acc, 8'd0} - 39'(pipe_q[NST-2].acc);
    sh  = 6'd30 + pipe_q[NST-2].k[5:0];
    vs  = v39 >> sh;
    if (pipe_q[NST-2].k >= 8'd34) begin
      sat = 8'd0;
    end else if (vs > 39'd255) begin
      sat = 8'd255;
    end else begin
      sat = vs[7:0];
    end
    case (pipe_q[NST-2].op)
      rgtg_pkg::OP_RAW:  pipe_d[NST-1].gray = pipe_q[NST-2].early;
      rgtg_pkg::OP_PROD: pipe_d[NST-1].gray = pipe_q[NST-2].early;
      rgtg_pkg::OP_POW: begin
        if (pipe_q[NST-2].zb) begin
          pipe_d[NST-1].gray = pipe_q[NST-2].ez ? 8'd255 : 8'd0;
        end else begin
          pipe_d[NST-1].gray = sat;
        end
      end
      default: pipe_d[NST-1].gray = 8'd0;
    endcase
  end

  // advance valid bits unless the output is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NST; s++) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

endmodule

>>> hw/rtl/rgb_component_to_gray_top.sv
// A request passes the queue, then the log, scaling, 16-step exp2 and output stages.
// Throughput: one pixel per cycle unless the output is held; exp2 is fully pipelined.
// A 4-entry queue sits between the mode decode and the arithmetic pipeline.
// Reset: mode 0, exponent 2.0 (Q4.12), queue and pipeline emptied.
`timescale 1ns / 1ps
`include "rgb_component_to_gray_top_macros.svh"
module rgb_component_to_gray_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  gray_o
);

  logic [3:0]       mode_q;
  logic [15:0]      exp_q;
  logic             push;
  logic             q_pop;
  rgtg_pkg::cmd_t   cmd_in;
  rgtg_pkg::cmd_t   cmd_out;
  rgtg_pkg::qstat_t q_stat;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 4'd0;
      exp_q  <= rgtg_pkg::EXP_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rgtg_pkg::CFG_MODE) begin
        mode_q <= cfg_data_i[3:0];
      end else begin
        exp_q <= cfg_data_i;
      end
    end
  end

  rgtg_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .mode_i     (mode_q),
    .exponent_i (exp_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  rgtg_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (q_pop),
    .cmd_o  (cmd_out),
    .stat_o (q_stat)
  );

  rgtg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (q_stat.valid),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gray_o      (gray_o)
  );

  `RGTG_ASSERT_IMP(a_pop_nonempty, q_pop, q_stat.valid)
  `RGTG_ASSERT_NXT(a_accept_queued, in_valid_i && in_ready_o, q_stat.valid)

endmodule

>>> tb/sv/tb_rgb_component_to_gray_top.sv
`timescale 1ns / 1ps
module tb_rgb_component_to_gray_top;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  gray_o;

  rgb_component_to_gray_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .red_i(red_i), .green_i(green_i), .blue_i(blue_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .gray_o(gray_o)
  );

  // shadow copy of the registers
  logic [3:0]  mode_q;
  logic [15:0] exp_q;
  logic [63:0] root_tab [17];

  logic [7:0]  gray_queue [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // floor square root, one result bit at a time from the top
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // base-2 log in Q16
  function automatic logic [31:0] log2_fix(input logic [31:0] n);
    int          msb;
    logic [63:0] m;
    logic [31:0] acc;
    msb = 0;
    for (int i = 0; i < 32; i++) if (n[i]) msb = i;
    m = (msb <= 16) ? (64'(n) << (16 - msb)) : (64'(n) >> (msb - 16));
    acc = 32'(msb) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 16;
      if (m >= 64'd131072) begin
        m = m >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  // 255 * (x/d)^e, e in Q4.12
  function automatic logic [7:0] gray_power(input logic [7:0] x, input logic [31:0] d,
                                            input logic [15:0] e);
    logic [31:0] lx;
    logic [31:0] ld;
    logic [63:0] diff;
    logic [63:0] t;
    logic [63:0] k;
    logic [15:0] frac;
    logic [63:0] prod;
    logic [63:0] val;
    if (x == 8'd0) return (e == 16'd0) ? 8'd255 : 8'd0;
    lx = log2_fix(32'(x));
    ld = log2_fix(d);
    diff = (ld > lx) ? 64'(ld - lx) : 64'd0;
    t = (diff * 64'(e)) >> 12;
    k = t >> 16;
    frac = t[15:0];
    prod = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) if (frac[16 - i]) prod = (prod * root_tab[i]) >> 30;
    if (k >= 64'd34) return 8'd0;
    val = (64'd255 * prod) >> (30 + k);
    return (val > 64'd255) ? 8'd255 : val[7:0];
  endfunction

  function automatic logic [7:0] predict_gray(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    case (mode_q)
      rgtg_pkg::MODE_R:        return r;
      rgtg_pkg::MODE_G:        return g;
      rgtg_pkg::MODE_B:        return b;
      rgtg_pkg::MODE_RG_PROD:  return 8'((16'(r) * 16'(g)) / 16'd255);
      rgtg_pkg::MODE_RB_PROD:  return 8'((16'(r) * 16'(b)) / 16'd255);
      rgtg_pkg::MODE_GB_PROD:  return 8'((16'(g) * 16'(b)) / 16'd255);
      rgtg_pkg::MODE_R_POW:    return gray_power(r, 32'd255, exp_q);
      rgtg_pkg::MODE_G_POW:    return gray_power(g, 32'd255, exp_q);
      rgtg_pkg::MODE_B_POW:    return gray_power(b, 32'd255, exp_q);
      rgtg_pkg::MODE_RG_RATIO: return gray_power(r, 32'(g) + 32'd255, rgtg_pkg::RATIO_EXP);
      rgtg_pkg::MODE_GB_RATIO: return gray_power(g, 32'(b) + 32'd255, rgtg_pkg::RATIO_EXP);
      rgtg_pkg::MODE_BR_RATIO: return gray_power(b, 32'(r) + 32'd255, rgtg_pkg::RATIO_EXP);
      default:                 return 8'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (gray_queue.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // empty the block, then drive one register write and hold it for one edge
  task automatic write_reg(input logic idx, input logic [15:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rgtg_pkg::CFG_MODE) mode_q = data[3:0];
    else exp_q = data;
    @(posedge clk_i);
  endtask

  // offer one pixel and wait for the request to be taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    gray_queue.push_back(predict_gray(r, g, b));
    @(posedge clk_i);
  endtask

  // accept results and compare with the oldest prediction
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gray_queue.size() == 0) report_mismatch("unexpected gray", 8'd0, gray_o);
      else begin
        logic [7:0] want;
        want = gray_queue.pop_front();
        if (gray_o !== want) report_mismatch("gray", want, gray_o);
      end
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed;
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_R));
    send_pixel(8'd0, 8'd255, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd128);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_G));
    send_pixel(8'd170, 8'd85, 8'd0);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_B));
    send_pixel(8'd85, 8'd170, 8'd255);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_RG_PROD));
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd254, 8'd0);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_RB_PROD));
    send_pixel(8'd128, 8'd0, 8'd2);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_GB_PROD));
    send_pixel(8'd0, 8'd200, 8'd255);
    // zero base with zero exponent saturates high
    write_reg(rgtg_pkg::CFG_EXP, 16'd0);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_R_POW));
    send_pixel(8'd0, 8'd9, 8'd9);
    send_pixel(8'd77, 8'd9, 8'd9);
    write_reg(rgtg_pkg::CFG_EXP, 16'hFFFF);
    send_pixel(8'd254, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    write_reg(rgtg_pkg::CFG_EXP, 16'd4096);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_G_POW));
    send_pixel(8'd3, 8'd100, 8'd3);
    write_reg(rgtg_pkg::CFG_EXP, 16'd1);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_B_POW));
    send_pixel(8'd3, 8'd3, 8'd0);
    send_pixel(8'd3, 8'd3, 8'd255);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_RG_RATIO));
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_GB_RATIO));
    send_pixel(8'd0, 8'd255, 8'd255);
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_BR_RATIO));
    send_pixel(8'd1, 8'd0, 8'd255);
    // unused modes, one with upper data bits set
    write_reg(rgtg_pkg::CFG_MODE, 16'hFFFC);
    send_pixel(8'd255, 8'd255, 8'd255);
    write_reg(rgtg_pkg::CFG_MODE, 16'h000F);
    send_pixel(8'd12, 8'd34, 8'd56);
    drain();
  endtask

  task automatic test_random;
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 66, 0, 7};
    stall_tab = '{0, 0, 66, 7};
    for (int ph = 0; ph < 8; ph++) begin
      int pick;
      send_idle_pct  = idle_tab[ph % 4];
      recv_stall_pct = stall_tab[ph % 4];
      pick = $urandom_range(3);
      write_reg(rgtg_pkg::CFG_EXP, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF
                : 16'($urandom_range(65535) >> $urandom_range(15)));
      for (int n = 0; n < 75; n++) begin
        if (n % 15 == 0) begin
          // mostly power and ratio modes, which hold most of the arithmetic
          write_reg(rgtg_pkg::CFG_MODE, ($urandom_range(3) == 0) ?
                    16'($urandom_range(65535)) : 16'($urandom_range(11, 6)));
        end
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(rgtg_pkg::CFG_MODE, 16'(rgtg_pkg::MODE_BR_RATIO));
    hold_cycles = 200;
    for (int n = 0; n < 40; n++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    drain();
  endtask

  initial begin
    for (int i = 0; i < 17; i++)
      root_tab[i] = (i == 0) ? (64'd1 << 29) : floor_sqrt(root_tab[i - 1] << 30);
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    mode_q         = rgtg_pkg::MODE_R;
    exp_q          = rgtg_pkg::EXP_RESET;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = rgtg_pkg::CFG_MODE;
    cfg_data_i     = 16'd0;
    in_valid_i     = 1'b0;
    red_i          = 8'd0;
    green_i        = 8'd0;
    blue_i         = 8'd0;
    out_ready_i    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset settings first: mode 0
    send_pixel(8'd200, 8'd1, 8'd2);
    drain();
    test_directed();
    test_random();
    test_backpressure();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
